// File: design/u8dl_pkg.sv
package u8dl_pkg;

	localparam int OFS_W  = 13;
	localparam int CP_W   = 21;
	localparam int LINE_W = 12;
	localparam int POS_W  = 32;
	localparam int ADV_W  = 20;

	localparam logic [OFS_W-1:0]  TEXT_MAX = 13'd4096;
	localparam logic [LINE_W-1:0] LINE_MAX = 12'd4095;
	localparam logic [7:0]        BYTE_LF  = 8'h0A;

	// item kinds
	localparam logic [1:0] KIND_GLYPH = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_BAD_LEAD = 3'd1;
	localparam logic [2:0] ERR_BAD_CONT = 3'd2;
	localparam logic [2:0] ERR_TRUNC    = 3'd3;
	localparam logic [2:0] ERR_BUDGET   = 3'd4;

	// config register indexes
	localparam logic [1:0] REG_ADVANCE     = 2'd0;
	localparam logic [1:0] REG_LINE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MAX_BYTES   = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} in_t;

	typedef struct packed {
		logic [1:0]        item_kind;
		logic [CP_W-1:0]   code_point;
		logic [OFS_W-1:0]  byte_begin;
		logic [OFS_W-1:0]  byte_end;
		logic [LINE_W-1:0] line_number;
		logic [POS_W-1:0]  origin_x;
		logic [POS_W-1:0]  origin_y;
		logic [2:0]        error_code;
		logic [OFS_W-1:0]  glyph_total;
		logic              run_last;
	} out_t;

	typedef struct packed {
		logic [ADV_W-1:0] advance_q;
		logic [ADV_W-1:0] line_height_q;
		logic [OFS_W-1:0] max_text_bytes;
	} cfg_t;

	typedef struct packed {
		logic [OFS_W-1:0]  byte_offset;
		logic [1:0]        bytes_remaining;
		logic [CP_W-1:0]   scalar_accum;
		logic [OFS_W-1:0]  sequence_start;
		logic [LINE_W-1:0] current_line;
		logic [POS_W-1:0]  pen_x;
		logic [POS_W-1:0]  pen_y;
		logic [OFS_W-1:0]  glyph_counter;
		logic              error_latched;
	} text_st_t;

endpackage

// File: design/u8dl_step.sv
module u8dl_step (
	input  u8dl_pkg::text_st_t cur,
	input  u8dl_pkg::in_t      req,
	input  u8dl_pkg::cfg_t     cfg,
	output u8dl_pkg::text_st_t nxt,
	output u8dl_pkg::out_t     res0,
	output u8dl_pkg::out_t     res1,
	output logic [1:0]         n_res
);
	import u8dl_pkg::*;

	logic [OFS_W-1:0]      budget;
	logic [2:0]            len;
	logic [CP_W-1:0]       lead_acc;
	logic [CP_W-1:0]       cont_acc;
	logic [2:0]            code;
	logic                  fin;
	logic                  is_nl;
	logic [CP_W-1:0]       cp;
	logic [LINE_W-1:0]     line_inc;
	logic [POS_W:0]        x_sum;
	logic [LINE_W+ADV_W-1:0] y_prod;
	logic                  emit_a;
	out_t                  item_a;
	out_t                  item_end;
	text_st_t              ns;

	assign budget = (cfg.max_text_bytes < TEXT_MAX) ? cfg.max_text_bytes : TEXT_MAX;

	// lead byte decode
	always_comb begin
		len      = 3'd0;
		lead_acc = '0;
		unique casez (req.text_byte)
			8'b0???????: begin
				len      = 3'd1;
				lead_acc = {13'd0, req.text_byte};
			end
			8'b110?????: begin
				len      = 3'd2;
				lead_acc = {16'd0, req.text_byte[4:0]};
			end
			8'b1110????: begin
				len      = 3'd3;
				lead_acc = {17'd0, req.text_byte[3:0]};
			end
			8'b11110???: begin
				len      = 3'd4;
				lead_acc = {18'd0, req.text_byte[2:0]};
			end
			default: begin
				len      = 3'd0;
				lead_acc = '0;
			end
		endcase
	end

	assign cont_acc = {cur.scalar_accum[CP_W-7:0], req.text_byte[5:0]};

	// saturating line bump; product of 12 and 20 bits never exceeds the position range
	assign line_inc = (cur.current_line < LINE_MAX) ? cur.current_line + 1'b1
	                                                : cur.current_line;
	assign y_prod   = line_inc * cfg.line_height_q;
	assign x_sum    = {1'b0, cur.pen_x} + {{(POS_W+1-ADV_W){1'b0}}, cfg.advance_q};

	always_comb begin
		ns    = cur;
		code  = ERR_NONE;
		fin   = 1'b0;
		is_nl = 1'b0;
		cp    = '0;
		if (!cur.error_latched) begin
			if (cur.byte_offset >= budget) begin
				code = ERR_BUDGET;
			end else if (cur.bytes_remaining == 2'd0) begin
				ns.sequence_start = cur.byte_offset;
				if (len == 3'd0) begin
					code = ERR_BAD_LEAD;
				end else begin
					ns.byte_offset = cur.byte_offset + 1'b1;
					if (len == 3'd1) begin
						fin   = 1'b1;
						cp    = lead_acc;
						is_nl = (req.text_byte == BYTE_LF);
					end else begin
						ns.scalar_accum    = lead_acc;
						ns.bytes_remaining = 2'(len - 3'd1);
						if (req.is_last)
							code = ERR_TRUNC;
					end
				end
			end else begin
				if (req.text_byte[7:6] != 2'b10) begin
					code = (req.is_last && cur.bytes_remaining > 2'd1) ? ERR_TRUNC
					                                                   : ERR_BAD_CONT;
				end else begin
					ns.byte_offset     = cur.byte_offset + 1'b1;
					ns.scalar_accum    = cont_acc;
					ns.bytes_remaining = cur.bytes_remaining - 1'b1;
					if (cur.bytes_remaining == 2'd1) begin
						fin = 1'b1;
						cp  = cont_acc;
					end else if (req.is_last) begin
						code = ERR_TRUNC;
					end
				end
			end
			if (fin) begin
				if (is_nl) begin
					ns.current_line = line_inc;
					ns.pen_x        = '0;
					ns.pen_y        = POS_W'(y_prod);
				end else begin
					ns.pen_x = x_sum[POS_W] ? {POS_W{1'b1}} : x_sum[POS_W-1:0];
					if (cur.glyph_counter < TEXT_MAX)
						ns.glyph_counter = cur.glyph_counter + 1'b1;
				end
			end
			if (code != ERR_NONE)
				ns.error_latched = 1'b1;
		end
	end

	// glyph or error record; the two never happen on the same byte
	always_comb begin
		item_a = '0;
		emit_a = 1'b0;
		if (code != ERR_NONE) begin
			emit_a            = 1'b1;
			item_a.item_kind  = KIND_ERROR;
			item_a.error_code = code;
		end else if (fin && !is_nl) begin
			emit_a             = 1'b1;
			item_a.item_kind   = KIND_GLYPH;
			item_a.code_point  = cp;
			item_a.byte_begin  = ns.sequence_start;
			item_a.byte_end    = ns.byte_offset;
			item_a.line_number = cur.current_line;
			item_a.origin_x    = cur.pen_x;
			item_a.origin_y    = cur.pen_y;
		end
		item_a.run_last = !req.is_last;
	end

	always_comb begin
		item_end             = '0;
		item_end.item_kind   = KIND_END;
		item_end.glyph_total = ns.glyph_counter;
		item_end.run_last    = 1'b1;
	end

	always_comb begin
		res1 = item_end;
		if (emit_a) begin
			res0  = item_a;
			n_res = req.is_last ? 2'd2 : 2'd1;
		end else begin
			res0  = item_end;
			n_res = req.is_last ? 2'd1 : 2'd0;
		end
		nxt = req.is_last ? text_st_t'('0) : ns;
	end

endmodule

// File: design/utf8_decode_cell_layout_core.sv
// An accepted request is held in the input stage and decoded once the queue has room for both
//   of its results; these are written to the result queue and show on out_valid from there.
// Throughput: one byte per cycle while the result queue has room, bounded by the single decode stage;
//   a byte that yields both a glyph or error and the end item puts two results in the queue.
// Reset: arst_n clears the input stage, result queue and text state, and loads the
//   configuration registers with advance 2048, line height 4096 and budget 4096.
module utf8_decode_cell_layout_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  u8dl_pkg::in_t             in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output u8dl_pkg::out_t            out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [u8dl_pkg::ADV_W-1:0] cfg_data
);
	import u8dl_pkg::*;

	localparam int QD = 4;

	// configuration registers
	cfg_t cfg_q;

	// input stage
	logic valid_s1;
	in_t  req_s1;

	// text state
	text_st_t st_q;
	text_st_t st_nxt;

	// step outputs
	out_t       res0;
	out_t       res1;
	logic [1:0] n_res;

	// result queue, four entries
	out_t       q_mem [QD];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       fire;
	logic       pop;

	// a byte is decoded only when the queue can take both of its results
	assign fire     = valid_s1 && (cnt_q <= 3'(QD - 2));
	assign in_ready = !valid_s1 || fire;
	assign pop      = out_valid && out_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.advance_q      <= 20'd2048;
			cfg_q.line_height_q  <= 20'd4096;
			cfg_q.max_text_bytes <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ADVANCE:     cfg_q.advance_q      <= cfg_data;
				REG_LINE_HEIGHT: cfg_q.line_height_q  <= cfg_data;
				REG_MAX_BYTES:   cfg_q.max_text_bytes <= cfg_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			req_s1 <= in_data;
	end

	u8dl_step u_step (
		.cur   (st_q),
		.req   (req_s1),
		.cfg   (cfg_q),
		.nxt   (st_nxt),
		.res0  (res0),
		.res1  (res1),
		.n_res (n_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (fire && n_res != 2'd0)
			q_mem[wr_ptr_q] <= res0;
		if (fire && n_res == 2'd2)
			q_mem[wr_ptr_q + 2'd1] <= res1;
	end

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire)
				wr_ptr_q <= wr_ptr_q + n_res;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + (fire ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
		end
	end

	assign out_valid = (cnt_q != 3'd0);
	assign out_data  = q_mem[rd_ptr_q];

endmodule

// File: tb/tb_utf8_decode_cell_layout_core.sv
module tb_utf8_decode_cell_layout_core;
	import u8dl_pkg::*;

	// Layout predictor: decodes the byte stream and queues every glyph,
	// error and end-of-text item the core should emit, in order.
	class glyph_layout;
		// configuration mirror
		logic [ADV_W-1:0]  advance;
		logic [ADV_W-1:0]  line_pitch;
		logic [OFS_W-1:0]  budget_reg;
		// per-text decode state
		logic [OFS_W-1:0]  offset;
		logic [1:0]        remaining;
		logic [CP_W-1:0]   accum;
		logic [OFS_W-1:0]  seq_begin;
		logic [LINE_W-1:0] line;
		logic [POS_W-1:0]  pen_x;
		logic [POS_W-1:0]  pen_y;
		logic [OFS_W-1:0]  glyph_count;
		bit                latched;
		out_t              step_items[$];
		out_t              items_due[$];
		int                failures;

		function new();
			advance    = 20'd2048;
			line_pitch = 20'd4096;
			budget_reg = 13'd4096;
			failures   = 0;
			clear_text();
		endfunction

		function void clear_text();
			offset      = '0;
			remaining   = '0;
			accum       = '0;
			seq_begin   = '0;
			line        = '0;
			pen_x       = '0;
			pen_y       = '0;
			glyph_count = '0;
			latched     = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [ADV_W-1:0] value);
			case (idx)
				REG_ADVANCE: begin
					advance = value;
				end
				REG_LINE_HEIGHT: begin
					line_pitch = value;
				end
				REG_MAX_BYTES: begin
					budget_reg = value[OFS_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// a lone LF moves the pen to the next line; anything else is a glyph
		function void place_scalar(logic [CP_W-1:0] cp, bit lf);
			logic [63:0] prod;
			logic [32:0] sum;
			out_t        item;
			if (lf) begin
				if (line < LINE_MAX)
					line = line + 1'b1;
				pen_x = '0;
				prod  = 64'(line) * 64'(line_pitch);
				pen_y = (prod > 64'hFFFF_FFFF) ? '1 : prod[31:0];
			end else begin
				item             = '0;
				item.item_kind   = KIND_GLYPH;
				item.code_point  = cp;
				item.byte_begin  = seq_begin;
				item.byte_end    = offset;
				item.line_number = line;
				item.origin_x    = pen_x;
				item.origin_y    = pen_y;
				step_items       = {step_items, item};
				sum   = {1'b0, pen_x} + 33'(advance);
				pen_x = sum[32] ? '1 : sum[31:0];
				if (glyph_count < TEXT_MAX)
					glyph_count = glyph_count + 1'b1;
			end
		endfunction

		// predicts the items of one accepted byte request
		function void note_byte(in_t req);
			logic [OFS_W-1:0] lim;
			logic [2:0]       code;
			int               len;
			logic [CP_W-1:0]  lead_bits;
			out_t             item;
			step_items.delete();
			code = ERR_NONE;
			if (!latched) begin
				lim = (budget_reg < TEXT_MAX) ? budget_reg : TEXT_MAX;
				if (offset >= lim) begin
					code = ERR_BUDGET;
				end else if (remaining == 0) begin
					seq_begin = offset;
					len       = 0;
					lead_bits = '0;
					if (!req.text_byte[7]) begin
						len = 1;
						lead_bits = CP_W'(req.text_byte);
					end else if (req.text_byte[7:5] == 3'b110) begin
						len = 2;
						lead_bits = CP_W'(req.text_byte[4:0]);
					end else if (req.text_byte[7:4] == 4'b1110) begin
						len = 3;
						lead_bits = CP_W'(req.text_byte[3:0]);
					end else if (req.text_byte[7:3] == 5'b11110) begin
						len = 4;
						lead_bits = CP_W'(req.text_byte[2:0]);
					end
					if (len == 0) begin
						code = ERR_BAD_LEAD;
					end else begin
						offset = offset + 1'b1;
						if (len == 1) begin
							place_scalar(lead_bits, req.text_byte == BYTE_LF);
						end else begin
							accum     = lead_bits;
							remaining = 2'(len - 1);
							if (req.is_last)
								code = ERR_TRUNC;
						end
					end
				end else if (req.text_byte[7:6] != 2'b10) begin
					// a text ending on a broken byte with more than one continuation still due counts as truncated
					code = (req.is_last && remaining > 1) ? ERR_TRUNC : ERR_BAD_CONT;
				end else begin
					offset    = offset + 1'b1;
					accum     = {accum[CP_W-7:0], req.text_byte[5:0]};
					remaining = remaining - 1'b1;
					if (remaining == 0)
						place_scalar(accum, 0);
					else if (req.is_last)
						code = ERR_TRUNC;
				end
				if (code != ERR_NONE) begin
					item            = '0;
					item.item_kind  = KIND_ERROR;
					item.error_code = code;
					step_items      = {step_items, item};
					latched = 1;
				end
			end
			if (req.is_last) begin
				item             = '0;
				item.item_kind   = KIND_END;
				item.glyph_total = glyph_count;
				step_items       = {step_items, item};
				clear_text();
			end
			if (step_items.size() > 0)
				step_items[step_items.size()-1].run_last = 1'b1;
			items_due = {items_due, step_items};
		endfunction

		function void match_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_item(out_t got);
			out_t want;
			if (items_due.size() == 0) begin
				$error("item_kind: expected no item, got 0x%0h", got.item_kind);
				failures++;
				return;
			end
			want = items_due.pop_front();
			match_field("item_kind",   32'(want.item_kind),   32'(got.item_kind));
			match_field("code_point",  32'(want.code_point),  32'(got.code_point));
			match_field("byte_begin",  32'(want.byte_begin),  32'(got.byte_begin));
			match_field("byte_end",    32'(want.byte_end),    32'(got.byte_end));
			match_field("line_number", 32'(want.line_number), 32'(got.line_number));
			match_field("origin_x",    want.origin_x,         got.origin_x);
			match_field("origin_y",    want.origin_y,         got.origin_y);
			match_field("error_code",  32'(want.error_code),  32'(got.error_code));
			match_field("glyph_total", 32'(want.glyph_total), 32'(got.glyph_total));
			match_field("run_last",    32'(want.run_last),    32'(got.run_last));
		endfunction

		function int pending();
			return items_due.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_t              in_data;
	logic             out_valid;
	logic             out_ready;
	out_t             out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [ADV_W-1:0] cfg_data;

	glyph_layout layout;
	logic [7:0]  text_q[$];   // bytes of the text being assembled
	int          sent_bytes;  // byte requests accepted so far
	bit          quiet;       // no idling on either side when set
	int          stall_left;

	utf8_decode_cell_layout_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well past the slowest legal run (every byte with two
	// results, every gap and stall at its longest).
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// Result side: ready drops in short random bursts unless quiet.
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 4) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Every accepted result goes against the oldest pending prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			layout.check_item(out_data);
	end

	// One byte request. Called at a falling edge, returns at the falling edge
	// after acceptance with valid still high; the caller drops it if idle.
	task automatic push_byte(input logic [7:0] value, input logic last);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {value, last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		layout.note_byte({value, last});
		sent_bytes++;
		@(negedge clk);
	endtask

	// Sends the assembled text, last flag on its final byte.
	task automatic flush_text();
		foreach (text_q[i])
			push_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	// Sender holds off until every predicted item is out, then lets bytes
	// that produce nothing drain as well.
	task automatic wait_settled();
		in_valid <= 1'b0;
		while (layout.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [ADV_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		layout.set_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic configure(input logic [ADV_W-1:0] adv, input logic [ADV_W-1:0] pitch,
			input logic [OFS_W-1:0] budget);
		write_reg(REG_ADVANCE, adv);
		write_reg(REG_LINE_HEIGHT, pitch);
		write_reg(REG_MAX_BYTES, ADV_W'(budget));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] lead_for(int len);
		case (len)
			2: return {3'b110, 5'($urandom)};
			3: return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// Mostly well-formed text with random scalars; some noise, some cut or
	// broken sequences.
	function automatic void build_text();
		int n_chars;
		int kind;
		int len;
		int cut;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				text_q = {text_q, 8'($urandom)};
			return;
		end
		n_chars = $urandom_range(1, 14);
		repeat (n_chars) begin
			kind = $urandom_range(0, 99);
			len  = $urandom_range(2, 4);
			if (kind < 30) begin
				text_q = {text_q, 8'($urandom_range(0, 127))};
			end else if (kind < 42) begin
				text_q = {text_q, BYTE_LF};
			end else if (kind < 90) begin
				text_q = {text_q, lead_for(len)};
				repeat (len - 1)
					text_q = {text_q, cont_byte()};
			end else begin
				// sequence cut short; sometimes followed by a non-continuation
				cut = $urandom_range(0, len - 2);
				text_q = {text_q, lead_for(len)};
				repeat (cut)
					text_q = {text_q, cont_byte()};
				if (kind >= 95)
					text_q = {text_q, {$urandom_range(0, 1) ? 2'b11 : 2'(1'($urandom)),
						6'($urandom)}};
			end
		end
	endfunction

	task automatic random_texts(input int n_bytes);
		int start;
		start = sent_bytes;
		while (sent_bytes - start < n_bytes) begin
			build_text();
			flush_text();
			// occasionally let the pipeline run dry before the next text
			if (!quiet && $urandom_range(0, 19) == 0)
				wait_settled();
		end
	endtask

	function automatic logic [ADV_W-1:0] pick_q8();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return ADV_W'($urandom);
		endcase
	endfunction

	function automatic logic [OFS_W-1:0] pick_budget();
		case ($urandom_range(0, 3))
			0: return 13'd1;
			1: return TEXT_MAX;
			2: return 13'($urandom_range(1, 32));
			default: return 13'($urandom_range(1, 4096));
		endcase
	endfunction

	initial begin
		layout     = new();
		sent_bytes = 0;
		quiet      = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_ADVANCE;
		cfg_data   = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: ASCII ends, LF, 2/3/4-byte scalars up to 0x1FFFFF,
		// glyph and end item on the same byte.
		text_q = '{8'h00, 8'h7F, 8'h0A, 8'hC2, 8'h80, 8'hE2, 8'h82, 8'hAC,
			8'hF7, 8'hBF, 8'hBF, 8'hBF};
		flush_text();
		text_q = '{8'h80};                  // stray continuation as lead
		flush_text();
		text_q = '{8'hFF};                  // 11111xxx lead
		flush_text();
		text_q = '{8'hE2};                  // text ends right after a lead
		flush_text();
		text_q = '{8'hE2, 8'h41};           // broken on last byte, two still due
		flush_text();
		text_q = '{8'hC2, 8'h41};           // broken on last byte, one due
		flush_text();
		text_q = '{8'hF0, 8'h90, 8'h80};    // ends mid-sequence after continuations
		flush_text();
		text_q = '{8'hE2, 8'h41, 8'h42};    // error mid-text, rest ignored
		flush_text();
		wait_settled();

		// Max advance and pitch, 24-byte budget: 24 glyphs then one byte over
		// budget, and a run of line feeds.
		configure('1, '1, 13'd24);
		repeat (24)
			text_q = {text_q, 8'($urandom_range(8'h20, 8'h7E))};
		text_q = {text_q, 8'h41};
		flush_text();
		repeat (20)
			text_q = {text_q, BYTE_LF};
		text_q = {text_q, 8'h5A};
		text_q = {text_q, 8'h41};
		flush_text();
		wait_settled();

		// Zero advance and pitch, one-byte budget.
		configure('0, '0, 13'd1);
		random_texts(30);
		wait_settled();

		for (int p = 0; p < 6; p++) begin
			configure(pick_q8(), pick_q8(), pick_budget());
			random_texts(140);
			wait_settled();
		end

		// Closing stretch with both sides streaming flat out.
		quiet = 1;
		configure(ADV_W'($urandom), ADV_W'($urandom), TEXT_MAX);
		random_texts(150);
		wait_settled();
		repeat (8) @(posedge clk);

		if (layout.failures == 0 && layout.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
design/u8dl_pkg.sv
design/u8dl_step.sv
design/utf8_decode_cell_layout_core.sv
tb/tb_utf8_decode_cell_layout_core.sv
